FILE: src/csem_pkg.sv
package csem_pkg;

  // operation codes
  localparam logic [2:0] OP_WAIT    = 3'd0;
  localparam logic [2:0] OP_TRYWAIT = 3'd1;
  localparam logic [2:0] OP_POST    = 3'd2;
  localparam logic [2:0] OP_INIT    = 3'd3;
  localparam logic [2:0] OP_DESTROY = 3'd4;

  // result codes
  localparam logic [2:0] RC_OK      = 3'd0;
  localparam logic [2:0] RC_QUEUED  = 3'd1;
  localparam logic [2:0] RC_UNAVAIL = 3'd2;
  localparam logic [2:0] RC_NOINIT  = 3'd3;
  localparam logic [2:0] RC_FULL    = 3'd4;

  localparam int unsigned INIT_WIDTH = 16;

endpackage

FILE: src/counting_semaphore_fifo_waiters.sv
// Counting semaphore with a FIFO of waiting thread ids. An op (wait, trywait,
// post, init, destroy) is taken at every clock edge where start is high and
// busy is low; busy stays low, so one op can be issued every cycle. The result
// of each op appears on result_code / woken_valid / woken_thread with done
// high for exactly one cycle, the cycle right after the op was taken, and it
// is transferred at the edge that ends that cycle: the receiver cannot stall,
// so it must take every result as it comes. The rate is one op per cycle. The
// waiter-id memory is written at the tail on a queued wait and read at the
// head on a post through a registered read. Count, pointers and occupancy
// are flip-flops updated at the transfer edge. The waiter memory is not
// cleared: only entries written by a queued wait are ever read back. A wait
// on a full queue reports queue full, a post with no waiter saturates the
// count, and init saturates init_value to the count width.
module counting_semaphore_fifo_waiters #(
  parameter int unsigned WAIT_DEPTH  = 16,
  parameter int unsigned ID_WIDTH    = 8,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          op,
  input  logic [ID_WIDTH-1:0]                 thread_id,
  input  logic [csem_pkg::INIT_WIDTH-1:0]     init_value,
  output logic                                done,
  output logic [2:0]                          result_code,
  output logic                                woken_valid,
  output logic [ID_WIDTH-1:0]                 woken_thread
);
  import csem_pkg::*;

  // pointer and occupancy widths
  localparam int unsigned PTR_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int unsigned OCC_W = $clog2(WAIT_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(WAIT_DEPTH - 1);
  localparam logic [OCC_W-1:0] FULL_OCC  = OCC_W'(WAIT_DEPTH);

  // init saturation is done at the wider of the two widths
  localparam int unsigned EXT_W = (COUNT_WIDTH > INIT_WIDTH) ? COUNT_WIDTH : INIT_WIDTH;
  localparam logic [EXT_W-1:0] COUNT_MAX_EXT = EXT_W'((64'd1 << COUNT_WIDTH) - 64'd1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // waiter id memory
  logic [ID_WIDTH-1:0] waiter_ids [WAIT_DEPTH];
  logic [ID_WIDTH-1:0] rd_data;

  // semaphore state
  logic                   initialized, initialized_next;
  logic [COUNT_WIDTH-1:0] count, count_next;
  logic [PTR_W-1:0]       head, head_next;
  logic [PTR_W-1:0]       tail, tail_next;
  logic [OCC_W-1:0]       occ, occ_next;

  // result register
  logic [2:0] rc_next;
  logic       wvalid_next;
  logic       wvalid;

  logic accept;
  logic wr_en;
  logic rd_en;
  logic [EXT_W-1:0] ival_ext;
  logic [EXT_W-1:0] ival_sat;

  // never stalls: every op finishes in the cycle after its transfer
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign ival_ext = EXT_W'(init_value);
  assign ival_sat = (ival_ext > COUNT_MAX_EXT) ? COUNT_MAX_EXT : ival_ext;

  always_comb begin
    initialized_next = initialized;
    count_next       = count;
    head_next        = head;
    tail_next        = tail;
    occ_next         = occ;
    rc_next          = RC_OK;
    wvalid_next      = 1'b0;
    wr_en            = 1'b0;
    rd_en            = 1'b0;
    if (op == OP_INIT) begin
      // init drops any queued waiters
      initialized_next = 1'b1;
      count_next       = COUNT_WIDTH'(ival_sat);
      head_next        = '0;
      tail_next        = '0;
      occ_next         = '0;
    end else if (!initialized) begin
      rc_next = RC_NOINIT;
    end else begin
      case (op)
        OP_WAIT: begin
          if (count != '0) begin
            count_next = count - COUNT_WIDTH'(1);
          end else if (occ == FULL_OCC) begin
            rc_next = RC_FULL;
          end else begin
            // block: append caller at tail
            wr_en     = 1'b1;
            tail_next = (tail == LAST_SLOT) ? '0 : tail + PTR_W'(1);
            occ_next  = occ + OCC_W'(1);
            rc_next   = RC_QUEUED;
          end
        end
        OP_TRYWAIT: begin
          if (count != '0) begin
            count_next = count - COUNT_WIDTH'(1);
          end else begin
            rc_next = RC_UNAVAIL;
          end
        end
        OP_POST: begin
          if (occ != '0) begin
            // hand the unit to the oldest waiter, id read from the head slot
            rd_en       = 1'b1;
            wvalid_next = 1'b1;
            head_next   = (head == LAST_SLOT) ? '0 : head + PTR_W'(1);
            occ_next    = occ - OCC_W'(1);
          end else if (count != COUNT_MAX) begin
            count_next = count + COUNT_WIDTH'(1);
          end
        end
        OP_DESTROY: begin
          initialized_next = 1'b0;
          count_next       = '0;
          head_next        = '0;
          tail_next        = '0;
          occ_next         = '0;
        end
        default: begin
          // unused op codes change nothing
          rc_next = RC_UNAVAIL;
        end
      endcase
    end
  end

  // memory port: one write at tail, one registered read at head
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      waiter_ids[tail] <= thread_id;
    end
    if (accept && rd_en) begin
      rd_data <= waiter_ids[head];
    end
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      initialized <= 1'b0;
      count       <= '0;
      head        <= '0;
      tail        <= '0;
      occ         <= '0;
      done        <= 1'b0;
      wvalid      <= 1'b0;
      result_code <= RC_OK;
    end else begin
      done <= accept;
      if (accept) begin
        initialized <= initialized_next;
        count       <= count_next;
        head        <= head_next;
        tail        <= tail_next;
        occ         <= occ_next;
        wvalid      <= wvalid_next;
        result_code <= rc_next;
      end
    end
  end

  assign woken_valid  = wvalid;
  // woken id reads as zero when no waiter was woken
  assign woken_thread = wvalid ? rd_data : '0;

endmodule

FILE: src/csem_checker.sv
module csem_checker #(
  parameter int unsigned ID_WIDTH = 8
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic [2:0]                      op,
  input logic [ID_WIDTH-1:0]             thread_id,
  input logic [csem_pkg::INIT_WIDTH-1:0] init_value,
  input logic                            done,
  input logic [2:0]                      result_code,
  input logic                            woken_valid,
  input logic [ID_WIDTH-1:0]             woken_thread
);
  import csem_pkg::*;

  logic acc;
  assign acc = start && !busy;

  // every transfer gives exactly one result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    acc |=> done) else $error("missing result after transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !acc |=> !done) else $error("result without transfer");

  // a handoff is always a success and carries an id only when valid
  a_woken_ok: assert property (@(posedge clk) disable iff (rst)
    done && woken_valid |-> result_code == RC_OK) else $error("handoff with error code");

  a_woken_zero: assert property (@(posedge clk) disable iff (rst)
    done && !woken_valid |-> woken_thread == '0) else $error("stale woken id");

  // init empties the queue, so a post straight after it wakes nobody
  a_init_empties: assert property (@(posedge clk) disable iff (rst)
    (acc && op == OP_INIT) ##1 (acc && op == OP_POST) |=> !woken_valid)
    else $error("waiter survived init");

endmodule

bind counting_semaphore_fifo_waiters csem_checker #(.ID_WIDTH(ID_WIDTH)) u_csem_checker (.*);
